// File: rtl/color_temperature_to_rgb_core_defines.svh
// assertion macros shared by the color temperature core
`ifndef COLOR_TEMPERATURE_TO_RGB_CORE_DEFINES_SVH
`define COLOR_TEMPERATURE_TO_RGB_CORE_DEFINES_SVH

// checked only out of reset
`define CTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CTR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ctr_pkg.sv
// constants and types for the color temperature to rgb core
package ctr_pkg;

    // output fraction bits, 1.0 = 1 << frac bits
    localparam int CTR_FRAC_BITS = 15;

    // input word
    localparam int CTR_KW   = 14;
    localparam int CTR_IN_W = ((CTR_KW + 7) / 8) * 8;
    localparam logic [CTR_KW-1:0] CTR_K_MIN = 14'd1000;
    localparam logic [CTR_KW-1:0] CTR_K_MAX = 14'd15000;

    // polynomial coefficients scaled by 10^16
    localparam logic [63:0] CTR_P_ONE = 64'd10000000000000000;
    localparam logic [63:0] CTR_UN0   = 64'd8601177570000000;
    localparam logic [63:0] CTR_UN1   = 64'd1541182540000;
    localparam logic [63:0] CTR_UN2   = 64'd1286412120;
    localparam logic [63:0] CTR_UD1   = 64'd8424202350000;
    localparam logic [63:0] CTR_UD2   = 64'd7081451630;
    localparam logic [63:0] CTR_VN0   = 64'd3173987260000000;
    localparam logic [63:0] CTR_VN1   = 64'd422806245000;
    localparam logic [63:0] CTR_VN2   = 64'd420481691;
    localparam logic [63:0] CTR_VD1   = 64'd289741816000;
    localparam logic [63:0] CTR_VD2   = 64'd1614560530;

    // chromaticity quotient and divider widths
    localparam int CTR_Q_W   = 30;   // u, v in q30
    localparam int CTR_UN_W  = 59;   // polynomial numerators
    localparam int CTR_UD_W  = 61;   // polynomial denominators
    localparam int CTR_DEN_W = CTR_UD_W - CTR_Q_W;

    // xyz vector, matrix products and row sums
    localparam int CTR_VEC_W  = 35;
    localparam int CTR_PROD_W = 62;
    localparam int CTR_MAG_W  = 58;  // magnitude of a row sum
    localparam int CTR_RGB_QW = 35;  // magnitude of rgb in q30
    localparam int CTR_RGB_W  = CTR_RGB_QW + 1;
    localparam logic signed [CTR_VEC_W-1:0] CTR_FOUR_Q30 = 35'sd4294967296;

    // row sum / 10^7 as (sum >> 7) * ceil(2^68 / 5^7) >> 68, exact below 2^51
    localparam int CTR_PRE_SH = 7;
    localparam int CTR_LO_W   = 26;
    localparam int CTR_PP_W   = 2 * CTR_LO_W;
    localparam int CTR_ACC_W  = 2 * CTR_PP_W;
    localparam int CTR_RCP_SH = 68;
    localparam logic [CTR_PP_W-1:0] CTR_RECIP  = 52'd3777893186295717;
    localparam logic [CTR_LO_W-1:0] CTR_RCP_HI = CTR_RECIP[CTR_PP_W-1:CTR_LO_W];
    localparam logic [CTR_LO_W-1:0] CTR_RCP_LO = CTR_RECIP[CTR_LO_W-1:0];

    // xyz to linear srgb, scaled by 10^7
    localparam logic signed [26:0] CTR_XYZ2RGB [3][3] = '{
        '{ 27'sd32404542, -27'sd15371385, -27'sd4985314 },
        '{ -27'sd9692660,  27'sd18760108,   27'sd415560 },
        '{   27'sd556434,  -27'sd2040259,  27'sd10572252 }
    };

    // status travelling beside the final division
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] sat;
        logic       zero;
    } ctr_flags_t;

endpackage

// File: rtl/ctr_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
module ctr_div_pipe #(
    parameter int LANES = 1,
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int QUO_W = 8,
    parameter int TAG_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [TAG_W-1:0]            tag,
    output logic                        out_valid,
    output logic [LANES-1:0][QUO_W-1:0] quo,
    output logic [TAG_W-1:0]            tag_out
);

    logic                        vld_reg [QUO_W];
    logic [LANES-1:0][DEN_W-1:0] rem_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] low_reg [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0]            den_reg [QUO_W];
    logic [TAG_W-1:0]            tag_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        logic                        v_i;
        logic [LANES-1:0][DEN_W-1:0] rem_i;
        logic [LANES-1:0][QUO_W-1:0] low_i;
        logic [LANES-1:0][QUO_W-1:0] quo_i;
        logic [DEN_W-1:0]            den_i;
        logic [TAG_W-1:0]            tag_i;
        logic [LANES-1:0][DEN_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0] low_next;
        logic [LANES-1:0][QUO_W-1:0] quo_next;

        // stage inputs: the operands or the previous stage
        if (j == 0)
        begin : g_first
            always_comb
            begin
                v_i   = in_valid;
                den_i = den;
                tag_i = tag;
                quo_i = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_i[l] = DEN_W'(num[l] >> QUO_W);
                    low_i[l] = num[l][QUO_W-1:0];
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_i   = vld_reg[j-1];
                den_i = den_reg[j-1];
                tag_i = tag_reg[j-1];
                rem_i = rem_reg[j-1];
                low_i = low_reg[j-1];
                quo_i = quo_reg[j-1];
            end
        end

        // bring down one bit, subtract when it fits
        always_comb
        begin
            logic [DEN_W:0] t;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                t           = {rem_i[l], low_i[l][QUO_W-1]};
                ge          = (t >= {1'b0, den_i});
                rem_next[l] = ge ? DEN_W'(t - {1'b0, den_i}) : t[DEN_W-1:0];
                low_next[l] = low_i[l] << 1;
                quo_next[l] = {quo_i[l][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                low_reg[j] <= low_next;
                quo_reg[j] <= quo_next;
                den_reg[j] <= den_i;
                tag_reg[j] <= tag_i;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign tag_out   = tag_reg[QUO_W-1];

endmodule

// File: rtl/color_temperature_to_rgb_core.sv
// color temperature to normalized linear srgb white point, top level
//
// Input stream s_*: one word per temperature, kelvin in s_tdata[13:0],
// clamped to 1000..15000. Output stream m_*: one word per input with red,
// green and blue as signed fixed point, 1 << FRAC_BITS meaning 1.0; the
// largest component is 1.0, negative ones saturate at -1.0.
// Most of the pipeline is two chains of divider stages, one quotient bit
// each: u and v in q30 and the division by the largest component; the
// division of the matrix rows by 10^7 is a two-stage reciprocal multiply.
// Throughput is one word per cycle; all stages advance together while the
// output register is empty or being taken, so a stalled receiver holds the
// whole pipeline and s_tready drops, with nothing lost or repeated.
// Reset clears the valid bits; the pipeline is empty and ready after it.
`include "color_temperature_to_rgb_core_defines.svh"

module color_temperature_to_rgb_core import ctr_pkg::*; #(
    parameter int FRAC_BITS = CTR_FRAC_BITS,
    localparam int OW    = FRAC_BITS + 2,
    localparam int OUT_W = ((3 * OW + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CTR_IN_W-1:0] s_tdata,   // kelvin
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // red, green, blue
);

    localparam logic signed [OW-1:0] ONE_Q = OW'(1) <<< FRAC_BITS;

    logic en;

    // stage 1: clamp and square
    logic                s1_vld_reg;
    logic [CTR_KW-1:0]   s1_k_reg;
    logic [2*CTR_KW-1:0] s1_k2_reg;
    logic [CTR_KW-1:0]   kc;

    // stage 2: polynomial terms
    logic        s2_vld_reg;
    logic [54:0] s2_un1_reg;
    logic [58:0] s2_un2_reg;
    logic [56:0] s2_ud1_reg;
    logic [60:0] s2_ud2_reg;
    logic [52:0] s2_vn1_reg;
    logic [56:0] s2_vn2_reg;
    logic [52:0] s2_vd1_reg;
    logic [58:0] s2_vd2_reg;

    // stage 3: numerators and q30 divisors
    logic                 s3_vld_reg;
    logic [CTR_UN_W-1:0]  s3_un_reg;
    logic [CTR_UN_W-1:0]  s3_vn_reg;
    logic [CTR_DEN_W-1:0] s3_du_reg;
    logic [CTR_DEN_W-1:0] s3_dv_reg;
    logic [63:0]          un_sum;
    logic [63:0]          ud_sum;
    logic [63:0]          vn_sum;
    logic [63:0]          vd_sum;

    // u, v dividers
    logic                 u_vld;
    logic                 v_vld;
    logic [0:0][CTR_Q_W-1:0] u_quo;
    logic [0:0][CTR_Q_W-1:0] v_quo;
    logic                 u_tag;
    logic                 v_tag;

    // stages 4 to 6: xyz vector, matrix, row sums
    logic                        s4_vld_reg;
    logic signed [CTR_VEC_W-1:0] s4_vec_reg [3];
    logic signed [CTR_VEC_W-1:0] uext;
    logic signed [CTR_VEC_W-1:0] vext;
    logic                         s5_vld_reg;
    logic signed [CTR_PROD_W-1:0] s5_prod_reg [3][3];
    logic                         s6_vld_reg;
    logic [2:0][CTR_MAG_W-1:0]    s6_mag_reg;
    logic [2:0]                   s6_neg_reg;
    logic [2:0][CTR_MAG_W-1:0]    mag_next;
    logic [2:0]                   neg_next;

    // row scaling by the reciprocal of 10^7
    logic                       sa_vld_reg;
    logic [2:0]                 sa_neg_reg;
    logic [2:0][CTR_PP_W-1:0]   sa_hh_reg;
    logic [2:0][CTR_PP_W-1:0]   sa_hl_reg;
    logic [2:0][CTR_PP_W-1:0]   sa_lh_reg;
    logic [2:0][CTR_PP_W-1:0]   sa_ll_reg;
    logic                       sb_vld_reg;
    logic [2:0]                 sb_neg_reg;
    logic [2:0][CTR_RGB_QW-1:0] sb_quo_reg;
    logic [2:0][CTR_RGB_QW-1:0] quo_next;

    // stages 7 to 9: signed rgb, maximum, division operands
    logic                        s7_vld_reg;
    logic signed [CTR_RGB_W-1:0] s7_rgb_reg [3];
    logic                        s8_vld_reg;
    logic signed [CTR_RGB_W-1:0] s8_rgb_reg [3];
    logic signed [CTR_RGB_W-1:0] s8_max_reg;
    logic signed [CTR_RGB_W-1:0] max_next;
    logic                                   s9_vld_reg;
    logic [2:0][CTR_RGB_QW+FRAC_BITS-1:0]   s9_num_reg;
    logic [CTR_RGB_QW-1:0]                  s9_den_reg;
    ctr_flags_t                             s9_flags_reg;
    logic [2:0][CTR_RGB_QW+FRAC_BITS-1:0]   num_next;
    logic [CTR_RGB_QW-1:0]                  den_next;
    ctr_flags_t                             flags_next;

    // final divider
    logic                      fd_vld;
    logic [2:0][FRAC_BITS:0]   fd_quo;
    ctr_flags_t                fd_flags;

    // output register
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [OUT_W-1:0]    m_tdata_next;
    logic signed [OW-1:0] comp_next [3];

    // whole pipeline moves unless a finished word is held
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s5_vld_reg   <= 1'b0;
            s6_vld_reg   <= 1'b0;
            sa_vld_reg   <= 1'b0;
            sb_vld_reg   <= 1'b0;
            s7_vld_reg   <= 1'b0;
            s8_vld_reg   <= 1'b0;
            s9_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg   <= s_tvalid;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= u_vld;
            s5_vld_reg   <= s4_vld_reg;
            s6_vld_reg   <= s5_vld_reg;
            sa_vld_reg   <= s6_vld_reg;
            sb_vld_reg   <= sa_vld_reg;
            s7_vld_reg   <= sb_vld_reg;
            s8_vld_reg   <= s7_vld_reg;
            s9_vld_reg   <= s8_vld_reg;
            m_tvalid_reg <= fd_vld;
        end
    end

    // clamp the temperature
    always_comb
    begin
        kc = s_tdata[CTR_KW-1:0];
        if (kc < CTR_K_MIN)
        begin
            kc = CTR_K_MIN;
        end
        else if (kc > CTR_K_MAX)
        begin
            kc = CTR_K_MAX;
        end
    end

    // polynomial sums and divisors
    always_comb
    begin
        un_sum = CTR_UN0 + 64'(s2_un1_reg) + 64'(s2_un2_reg);
        ud_sum = CTR_P_ONE + 64'(s2_ud1_reg) + 64'(s2_ud2_reg);
        vn_sum = CTR_VN0 + 64'(s2_vn1_reg) + 64'(s2_vn2_reg);
        vd_sum = CTR_P_ONE + 64'(s2_vd2_reg) - 64'(s2_vd1_reg);
    end

    // stages 1 to 3
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_k_reg   <= kc;
            s1_k2_reg  <= kc * kc;
            s2_un1_reg <= 55'(CTR_UN1 * s1_k_reg);
            s2_un2_reg <= 59'(CTR_UN2 * s1_k2_reg);
            s2_ud1_reg <= 57'(CTR_UD1 * s1_k_reg);
            s2_ud2_reg <= 61'(CTR_UD2 * s1_k2_reg);
            s2_vn1_reg <= 53'(CTR_VN1 * s1_k_reg);
            s2_vn2_reg <= 57'(CTR_VN2 * s1_k2_reg);
            s2_vd1_reg <= 53'(CTR_VD1 * s1_k_reg);
            s2_vd2_reg <= 59'(CTR_VD2 * s1_k2_reg);
            s3_un_reg  <= un_sum[CTR_UN_W-1:0];
            s3_vn_reg  <= vn_sum[CTR_UN_W-1:0];
            s3_du_reg  <= (ud_sum[CTR_UD_W-1:CTR_Q_W] == '0) ? CTR_DEN_W'(1)
                                                            : ud_sum[CTR_UD_W-1:CTR_Q_W];
            s3_dv_reg  <= (vd_sum[CTR_UD_W-1:CTR_Q_W] == '0) ? CTR_DEN_W'(1)
                                                            : vd_sum[CTR_UD_W-1:CTR_Q_W];
        end
    end

    // u and v in q30
    ctr_div_pipe #(
        .LANES (1),
        .NUM_W (CTR_UN_W),
        .DEN_W (CTR_DEN_W),
        .QUO_W (CTR_Q_W),
        .TAG_W (1)
    ) u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .num       (s3_un_reg),
        .den       (s3_du_reg),
        .tag       (1'b0),
        .out_valid (u_vld),
        .quo       (u_quo),
        .tag_out   (u_tag)
    );

    ctr_div_pipe #(
        .LANES (1),
        .NUM_W (CTR_UN_W),
        .DEN_W (CTR_DEN_W),
        .QUO_W (CTR_Q_W),
        .TAG_W (1)
    ) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .num       (s3_vn_reg),
        .den       (s3_dv_reg),
        .tag       (1'b0),
        .out_valid (v_vld),
        .quo       (v_quo),
        .tag_out   (v_tag)
    );

    // xyz scaled by 2v, row sums with sign and magnitude
    always_comb
    begin
        logic signed [63:0] sum;
        logic [63:0]        a;
        uext = signed'(CTR_VEC_W'(u_quo[0]));
        vext = signed'(CTR_VEC_W'(v_quo[0]));
        for (int i = 0; i < 3; i++)
        begin
            sum = 64'(s5_prod_reg[i][0]) + 64'(s5_prod_reg[i][1])
                + 64'(s5_prod_reg[i][2]);
            neg_next[i] = sum[63];
            a = sum[63] ? 64'(-sum) : 64'(sum);
            mag_next[i] = a[CTR_MAG_W-1:0];
        end
    end

    // stages 4 to 6
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_vec_reg[0] <= uext + (uext <<< 1);
            s4_vec_reg[1] <= vext <<< 1;
            s4_vec_reg[2] <= CTR_FOUR_Q30 - uext - (vext <<< 3) - (vext <<< 1);
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s5_prod_reg[i][j] <= CTR_PROD_W'(CTR_XYZ2RGB[i][j])
                                       * CTR_PROD_W'(s4_vec_reg[j]);
                end
            end
            s6_mag_reg <= mag_next;
            s6_neg_reg <= neg_next;
        end
    end

    // reciprocal product summed and shifted down to the quotient
    always_comb
    begin
        logic [CTR_ACC_W-1:0] p;
        for (int i = 0; i < 3; i++)
        begin
            p = (CTR_ACC_W'(sa_hh_reg[i]) << CTR_PP_W)
              + (CTR_ACC_W'(sa_hl_reg[i]) << CTR_LO_W)
              + (CTR_ACC_W'(sa_lh_reg[i]) << CTR_LO_W)
              + CTR_ACC_W'(sa_ll_reg[i]);
            quo_next[i] = p[CTR_RCP_SH+CTR_RGB_QW-1:CTR_RCP_SH];
        end
    end

    // rows divided by the matrix scale: partial products, then the sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sa_hh_reg[i] <= CTR_PP_W'(s6_mag_reg[i][CTR_MAG_W-1:CTR_PRE_SH+CTR_LO_W])
                              * CTR_PP_W'(CTR_RCP_HI);
                sa_hl_reg[i] <= CTR_PP_W'(s6_mag_reg[i][CTR_MAG_W-1:CTR_PRE_SH+CTR_LO_W])
                              * CTR_PP_W'(CTR_RCP_LO);
                sa_lh_reg[i] <= CTR_PP_W'(s6_mag_reg[i][CTR_PRE_SH+CTR_LO_W-1:CTR_PRE_SH])
                              * CTR_PP_W'(CTR_RCP_HI);
                sa_ll_reg[i] <= CTR_PP_W'(s6_mag_reg[i][CTR_PRE_SH+CTR_LO_W-1:CTR_PRE_SH])
                              * CTR_PP_W'(CTR_RCP_LO);
            end
            sa_neg_reg <= s6_neg_reg;
            sb_quo_reg <= quo_next;
            sb_neg_reg <= sa_neg_reg;
        end
    end

    // largest component
    always_comb
    begin
        max_next = s7_rgb_reg[0];
        if (s7_rgb_reg[1] > max_next)
        begin
            max_next = s7_rgb_reg[1];
        end
        if (s7_rgb_reg[2] > max_next)
        begin
            max_next = s7_rgb_reg[2];
        end
    end

    // division operands and saturation flags
    always_comb
    begin
        logic [CTR_RGB_W-1:0] m;
        flags_next.zero = (s8_max_reg <= CTR_RGB_W'(0));
        den_next = flags_next.zero ? CTR_RGB_QW'(1) : s8_max_reg[CTR_RGB_QW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            flags_next.neg[i] = s8_rgb_reg[i][CTR_RGB_W-1];
            m = flags_next.neg[i] ? CTR_RGB_W'(-s8_rgb_reg[i]) : CTR_RGB_W'(s8_rgb_reg[i]);
            flags_next.sat[i] = flags_next.neg[i]
                              && (m[CTR_RGB_QW-1:0] > s8_max_reg[CTR_RGB_QW-1:0]);
            num_next[i] = (flags_next.zero || flags_next.sat[i]) ? '0
                        : {m[CTR_RGB_QW-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    // stages 7 to 9
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_rgb_reg[i] <= sb_neg_reg[i] ? -signed'({1'b0, sb_quo_reg[i]})
                                               : signed'({1'b0, sb_quo_reg[i]});
                s8_rgb_reg[i] <= s7_rgb_reg[i];
            end
            s8_max_reg   <= max_next;
            s9_num_reg   <= num_next;
            s9_den_reg   <= den_next;
            s9_flags_reg <= flags_next;
        end
    end

    // components divided by the largest one
    ctr_div_pipe #(
        .LANES (3),
        .NUM_W (CTR_RGB_QW + FRAC_BITS),
        .DEN_W (CTR_RGB_QW),
        .QUO_W (FRAC_BITS + 1),
        .TAG_W ($bits(ctr_flags_t))
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_vld_reg),
        .num       (s9_num_reg),
        .den       (s9_den_reg),
        .tag       (s9_flags_reg),
        .out_valid (fd_vld),
        .quo       (fd_quo),
        .tag_out   (fd_flags)
    );

    // sign, saturation and packing
    always_comb
    begin
        logic signed [OW-1:0] pos;
        for (int i = 0; i < 3; i++)
        begin
            pos = signed'(OW'(fd_quo[i]));
            if (fd_flags.zero)
            begin
                comp_next[i] = '0;
            end
            else if (fd_flags.sat[i])
            begin
                comp_next[i] = -ONE_Q;
            end
            else if (fd_flags.neg[i])
            begin
                comp_next[i] = -pos;
            end
            else
            begin
                comp_next[i] = pos;
            end
        end
        m_tdata_next = OUT_W'({comp_next[2], comp_next[1], comp_next[0]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // output components for checking
    logic signed [OW-1:0] red_w;
    logic signed [OW-1:0] green_w;
    logic signed [OW-1:0] blue_w;

    assign red_w   = signed'(m_tdata[OW-1:0]);
    assign green_w = signed'(m_tdata[2*OW-1:OW]);
    assign blue_w  = signed'(m_tdata[3*OW-1:2*OW]);

    `CTR_ASSERT_ALWAYS(a_uv_aligned, (u_vld == v_vld) && (!u_vld || u_tag == v_tag), "u and v dividers out of step")
    `CTR_ASSERT(a_max_is_one, m_tvalid |-> (red_w == ONE_Q || green_w == ONE_Q || blue_w == ONE_Q), "no component equals 1.0")
    `CTR_ASSERT(a_red_range, m_tvalid |-> (red_w >= -ONE_Q && red_w <= ONE_Q), "red out of range")
    `CTR_ASSERT(a_blue_range, m_tvalid |-> (blue_w >= -ONE_Q && blue_w <= ONE_Q), "blue out of range")

endmodule
